### hw/rtl/abre_pkg.sv
// Shared types and constants for the adaptive binary range encoder.
// No dependencies; every other RTL file but abre_checker imports this package.
`default_nettype none

package abre_pkg;

    localparam int PROB_W    = 12;
    localparam int SHIFT_W   = 4;
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [PROB_W-1:0] PROB_INIT = 12'h800;
    localparam logic [PROB_W:0]   PROB_ONE  = 13'h1000;

    localparam logic [31:0] RANGE_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP_VALUE     = 32'h0100_0000;
    localparam logic [31:0] RENORM2_LIMIT = 32'h0001_0000;

    localparam logic [7:0] CACHE_INIT    = 8'hFF;
    localparam logic [7:0] DEFER_BYTE    = 8'hFF;
    localparam logic [7:0] FILL_NO_CARRY = 8'hFF;
    localparam logic [7:0] FILL_CARRY    = 8'h00;

    // flush events run by a finish word
    localparam logic [2:0] FLUSH_FINISH = 3'd5;

    localparam logic [2:0] MODEL_TYPE       = 3'd0;
    localparam logic [2:0] MODEL_LITERAL    = 3'd1;
    localparam logic [2:0] MODEL_LEN_PREFIX = 3'd2;
    localparam logic [2:0] MODEL_LEN_SUFFIX = 3'd3;
    localparam logic [2:0] MODEL_OFF_PREFIX = 3'd4;
    localparam logic [2:0] MODEL_OFF_SUFFIX = 3'd5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET_DEFAULT = 4'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET_LITERAL = 4'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN           = 4'd1;

    typedef enum logic [1:0] {
        STORE_TYPE,
        STORE_LIT,
        STORE_CODE
    } store_t;

    typedef enum logic {
        OP_BIT,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic       valid;
        store_t     store;
        logic [2:0] model;
        logic [7:0] slot;
    } prob_rd_t;

    typedef struct packed {
        logic              we;
        logic [PROB_W-1:0] data;
    } prob_wr_t;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic        bit_value;
        logic [31:0] thr;
    } coder_cmd_t;

    typedef struct packed {
        logic [23:0] count;
        logic [7:0]  fill;
        logic [7:0]  lead;
    } flush_word_t;

endpackage

`default_nettype wire

### hw/rtl/abre_prob_store.sv
// Probability stores: type register, literal memory and code memory,
// with the clearing sweep after reset and same-entry forwarding. Uses abre_pkg.
`default_nettype none

module abre_prob_store
    import abre_pkg::*;
#(
    parameter int LITERAL_SLOTS = 256,
    parameter int CODE_SLOTS    = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prob_rd_t          rd,
    input  wire prob_wr_t          wr,
    output logic [PROB_W-1:0]      rd_prob,
    output logic                   busy
);

    localparam int LIT_AW     = $clog2(LITERAL_SLOTS);
    localparam int CODE_AW    = $clog2(CODE_SLOTS);
    localparam int CODE_DEPTH = 4 * CODE_SLOTS;
    localparam int CA_W       = $clog2(CODE_DEPTH);
    localparam int CLR_DEPTH  = (LITERAL_SLOTS > CODE_DEPTH) ? LITERAL_SLOTS : CODE_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    logic [PROB_W-1:0] lit_mem  [LITERAL_SLOTS];
    logic [PROB_W-1:0] code_mem [CODE_DEPTH];

    // slot wrap tables, built at elaboration
    logic [LIT_AW-1:0]  lit_tbl  [256];
    logic [CODE_AW-1:0] code_tbl [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_wrap
        assign lit_tbl[gi]  = LIT_AW'(gi % LITERAL_SLOTS);
        assign code_tbl[gi] = CODE_AW'(gi % CODE_SLOTS);
    end

    logic [LIT_AW-1:0]  lit_addr;
    logic [CA_W-1:0]    code_addr;
    logic               same_entry;

    logic               clr_active_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic               clr_lit_we;
    logic               clr_code_we;

    store_t             sel_reg;
    logic [LIT_AW-1:0]  lit_waddr_reg;
    logic [CA_W-1:0]    code_waddr_reg;
    logic [PROB_W-1:0]  lit_rdata_reg;
    logic [PROB_W-1:0]  code_rdata_reg;
    logic [PROB_W-1:0]  type_prob_reg;
    logic               fwd_valid_reg;
    logic [PROB_W-1:0]  fwd_data_reg;

    assign lit_addr  = lit_tbl[rd.slot];
    assign code_addr = CA_W'(rd.model - MODEL_LEN_PREFIX) * CA_W'(CODE_SLOTS)
                     + CA_W'(code_tbl[rd.slot]);

    always_comb
    begin
        same_entry = 1'b0;
        if (rd.store == sel_reg)
        begin
            case (rd.store)
                STORE_LIT:  same_entry = (lit_addr == lit_waddr_reg);
                STORE_CODE: same_entry = (code_addr == code_waddr_reg);
                default:    same_entry = 1'b0;
            endcase
        end
    end

    assign clr_lit_we  = clr_active_reg && ({1'b0, clr_cnt_reg} < (CLR_W+1)'(LITERAL_SLOTS));
    assign clr_code_we = clr_active_reg && ({1'b0, clr_cnt_reg} < (CLR_W+1)'(CODE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (clr_lit_we)
        begin
            lit_mem[clr_cnt_reg[LIT_AW-1:0]] <= PROB_INIT;
        end
        else if (wr.we && sel_reg == STORE_LIT)
        begin
            lit_mem[lit_waddr_reg] <= wr.data;
        end
        if (rd.valid && rd.store == STORE_LIT)
        begin
            lit_rdata_reg <= lit_mem[lit_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_code_we)
        begin
            code_mem[clr_cnt_reg[CA_W-1:0]] <= PROB_INIT;
        end
        else if (wr.we && sel_reg == STORE_CODE)
        begin
            code_mem[code_waddr_reg] <= wr.data;
        end
        if (rd.valid && rd.store == STORE_CODE)
        begin
            code_rdata_reg <= code_mem[code_addr];
        end
    end

    // read address is kept: the held word writes back to its own entry
    always_ff @(posedge clk)
    begin
        if (rd.valid)
        begin
            lit_waddr_reg  <= lit_addr;
            code_waddr_reg <= code_addr;
            fwd_data_reg   <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            type_prob_reg  <= PROB_INIT;
            fwd_valid_reg  <= 1'b0;
            sel_reg        <= STORE_TYPE;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (wr.we && sel_reg == STORE_TYPE)
            begin
                type_prob_reg <= wr.data;
            end
            if (rd.valid)
            begin
                // write-back landing on the entry just read: memory gave stale data
                fwd_valid_reg <= wr.we && same_entry;
                sel_reg       <= rd.store;
            end
        end
    end

    always_comb
    begin
        case (sel_reg)
            STORE_TYPE: rd_prob = type_prob_reg;
            STORE_LIT:  rd_prob = fwd_valid_reg ? fwd_data_reg : lit_rdata_reg;
            STORE_CODE: rd_prob = fwd_valid_reg ? fwd_data_reg : code_rdata_reg;
            default:    rd_prob = PROB_INIT;
        endcase
    end

    assign busy = clr_active_reg;

endmodule

`default_nettype wire

### hw/rtl/abre_coder.sv
// Range/low update, bytewise renormalization with carry caching, and the
// flush unit with its one-word hold slot and output register. Uses abre_pkg.
`default_nettype none

module abre_coder
    import abre_pkg::*;
#(
    parameter int PENDING_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire coder_cmd_t  cmd,
    output logic             cmd_ready,
    output logic [31:0]      cur_range,
    output logic             out_valid,
    input  wire logic        out_ready,
    output flush_word_t      out_word,
    output logic             out_last
);

    localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};

    logic [31:0]             range_reg;
    logic [32:0]             low_reg;
    logic [7:0]              cache_reg;
    logic [PENDING_BITS-1:0] pend_reg;
    logic [2:0]              flush_left_reg;
    logic                    hold_valid_reg;
    logic                    hold_last_reg;
    flush_word_t             hold_word_reg;
    logic                    out_valid_reg;
    flush_word_t             out_word_reg;
    logic                    out_last_reg;

    logic                    take;
    logic [31:0]             range_new;
    logic [31:0]             range_next;
    logic [32:0]             low_next;
    logic [2:0]              nflush;

    logic                    carry;
    logic                    fl_cond;
    logic                    fl_emit;
    logic [PENDING_BITS-1:0] pend_m1;
    logic [PENDING_BITS+23:0] pend_m1_wide;
    flush_word_t             fl_word;
    logic                    flushing;
    logic                    last_flush;
    logic                    out_free;
    logic                    push;
    logic                    flush_go;

    assign cmd_ready = (flush_left_reg == 3'd0);
    assign take      = cmd.valid && cmd_ready;

    always_comb
    begin
        range_new = cmd.bit_value ? (range_reg - cmd.thr) : cmd.thr;
        low_next  = cmd.bit_value ? (low_reg + {1'b0, cmd.thr}) : low_reg;
        // the split leaves at least 2^12, so two byte shifts at most
        if (range_new < RENORM2_LIMIT)
        begin
            nflush     = 3'd2;
            range_next = {range_new[15:0], 16'h0000};
        end
        else if (range_new < TOP_VALUE)
        begin
            nflush     = 3'd1;
            range_next = {range_new[23:0], 8'h00};
        end
        else
        begin
            nflush     = 3'd0;
            range_next = range_new;
        end
    end

    assign carry        = low_reg[32];
    assign fl_cond      = carry || (low_reg[31:24] != DEFER_BYTE);
    assign fl_emit      = fl_cond && (pend_reg != '0);
    assign pend_m1      = pend_reg - 1'b1;
    assign pend_m1_wide = {24'd0, pend_m1};

    always_comb
    begin
        fl_word.lead  = cache_reg + {7'd0, carry};
        fl_word.fill  = carry ? FILL_CARRY : FILL_NO_CARRY;
        fl_word.count = pend_m1_wide[23:0];
    end

    assign flushing   = (flush_left_reg != 3'd0);
    assign last_flush = (flush_left_reg == 3'd1);
    assign out_free   = !out_valid_reg || out_ready;
    // held word leaves once it is known whether a later flush of its word emits
    assign push       = hold_valid_reg && out_free && (hold_last_reg || (flushing && fl_emit));
    assign flush_go   = flushing && (!fl_emit || !hold_valid_reg || push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg      <= RANGE_INIT;
            low_reg        <= '0;
            cache_reg      <= CACHE_INIT;
            pend_reg       <= '0;
            flush_left_reg <= 3'd0;
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (cmd.op == OP_BIT)
                begin
                    range_reg      <= range_next;
                    low_reg        <= low_next;
                    flush_left_reg <= nflush;
                end
                else
                begin
                    flush_left_reg <= FLUSH_FINISH;
                end
            end
            else if (flush_go)
            begin
                low_reg        <= {1'b0, low_reg[23:0], 8'h00};
                flush_left_reg <= flush_left_reg - 1'b1;
                if (fl_cond)
                begin
                    cache_reg <= low_reg[31:24];
                    pend_reg  <= {{(PENDING_BITS-1){1'b0}}, 1'b1};
                end
                else if (pend_reg != PEND_MAX)
                begin
                    pend_reg <= pend_reg + 1'b1;
                end
            end

            if (flush_go && fl_emit)
            begin
                hold_valid_reg <= 1'b1;
                hold_last_reg  <= last_flush;
            end
            else
            begin
                if (push)
                begin
                    hold_valid_reg <= 1'b0;
                end
                if (flush_go && last_flush)
                begin
                    hold_last_reg <= 1'b1;
                end
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flush_go && fl_emit)
        begin
            hold_word_reg <= fl_word;
        end
        if (push)
        begin
            out_word_reg <= hold_word_reg;
            out_last_reg <= hold_last_reg;
        end
    end

    assign cur_range = range_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/adaptive_binary_range_encoder.sv
// Top level of the adaptive binary range encoder: input stage, probability
// update and range multiply stage, configuration registers. Uses abre_pkg,
// abre_prob_store and abre_coder.
//
// A coded bit's (range >> 12) * prob multiply waits for the range update of
// the bit before it. A bit whose renormalization shifts out two bytes runs two
// flush events, and the flush unit handles one flush event per cycle unless the
// hold slot or the output stalls it; a finish word runs five flush events.
// Results leave at most one per cycle through an output register, and the
// result carrying tlast is released once the last flush of its word has run.
// After reset a sweep clears the probability memories over
// max(LITERAL_SLOTS, 4*CODE_SLOTS) addresses (256 at the defaults), with
// s_axis_tready low. Shift registers may only be written while the block is idle.
`default_nettype none

module adaptive_binary_range_encoder
    import abre_pkg::*;
#(
    parameter int LITERAL_SLOTS = 256,
    parameter int CODE_SLOTS    = 32,
    parameter int PENDING_BITS  = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_addr,
    input  wire logic [SHIFT_W-1:0]   cfg_wdata,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // bit_value, model[2:0], slot[7:0], pad
    input  wire logic                 s_axis_tuser,   // mode

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,   // lead_byte, fill_byte, fill_count[23:0]
    output logic                      m_axis_tlast
);

    logic [SHIFT_W-1:0] shift_reg [NUM_REGS];

    logic               in_mode;
    logic               in_bit;
    logic [2:0]         in_model;
    logic [7:0]         in_slot;
    logic               in_accept;
    logic               in_nop;
    logic               s1_take;
    store_t             in_store;
    logic [SHIFT_W-1:0] sh_raw;
    logic [SHIFT_W-1:0] sh_next;

    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic               s1_bit_reg;
    logic [SHIFT_W-1:0] s1_shift_reg;
    logic               s1_move;

    logic               m_valid_reg;
    op_t                m_op_reg;
    logic               m_bit_reg;
    logic [31:0]        m_thr_reg;

    prob_rd_t           rd;
    prob_wr_t           wr;
    logic [PROB_W-1:0]  prob;
    logic [PROB_W-1:0]  prob_dec;
    logic [PROB_W:0]    prob_inc;
    logic [PROB_W-1:0]  prob_next;
    logic [31:0]        thr_next;
    logic               busy;

    coder_cmd_t         cmd;
    logic               cmd_ready;
    logic [31:0]        cur_range;
    flush_word_t        out_word;

    assign in_mode  = s_axis_tuser;
    assign in_bit   = s_axis_tdata[0];
    assign in_model = s_axis_tdata[3:1];
    assign in_slot  = s_axis_tdata[11:4];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_nop    = !in_mode && (in_model > MODEL_OFF_SUFFIX);
    assign s1_take   = in_accept && !in_nop;

    always_comb
    begin
        case (in_model)
            MODEL_TYPE:       in_store = STORE_TYPE;
            MODEL_LITERAL:    in_store = STORE_LIT;
            default:          in_store = STORE_CODE;
        endcase
        case (in_model)
            MODEL_TYPE:       sh_raw = shift_reg[MODEL_TYPE];
            MODEL_LITERAL:    sh_raw = shift_reg[MODEL_LITERAL];
            MODEL_LEN_PREFIX: sh_raw = shift_reg[MODEL_LEN_PREFIX];
            MODEL_LEN_SUFFIX: sh_raw = shift_reg[MODEL_LEN_SUFFIX];
            MODEL_OFF_PREFIX: sh_raw = shift_reg[MODEL_OFF_PREFIX];
            MODEL_OFF_SUFFIX: sh_raw = shift_reg[MODEL_OFF_SUFFIX];
            default:          sh_raw = SHIFT_MIN;
        endcase
        // a zero shift acts as one, keeping the probability inside 1..0xFFF
        sh_next = (sh_raw == '0) ? SHIFT_MIN : sh_raw;
    end

    assign rd = '{valid: s1_take && !in_mode, store: in_store, model: in_model, slot: in_slot};

    assign s1_move       = s1_valid_reg && !m_valid_reg;
    assign s_axis_tready = !busy && (!s1_valid_reg || s1_move);

    // probability adaptation and range split share the fetched probability
    assign prob_dec  = prob >> s1_shift_reg;
    assign prob_inc  = (PROB_ONE - {1'b0, prob}) >> s1_shift_reg;
    assign prob_next = s1_bit_reg ? (prob - prob_dec) : (prob + prob_inc[PROB_W-1:0]);
    assign thr_next  = 32'(cur_range[31:12]) * 32'(prob);

    assign wr = '{we: s1_move && (s1_op_reg == OP_BIT), data: prob_next};

    assign cmd = '{valid: m_valid_reg, op: m_op_reg, bit_value: m_bit_reg, thr: m_thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                shift_reg[i] <= (i == MODEL_LITERAL) ? SHIFT_RESET_LITERAL
                                                     : SHIFT_RESET_DEFAULT;
            end
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr < REG_IDX_W'(NUM_REGS))
            begin
                shift_reg[cfg_addr] <= cfg_wdata;
            end

            if (s1_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (cmd_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_op_reg    <= in_mode ? OP_FINISH : OP_BIT;
            s1_bit_reg   <= in_bit;
            s1_shift_reg <= sh_next;
        end
        if (s1_move)
        begin
            m_op_reg  <= s1_op_reg;
            m_bit_reg <= s1_bit_reg;
            m_thr_reg <= thr_next;
        end
    end

    abre_prob_store #(
        .LITERAL_SLOTS (LITERAL_SLOTS),
        .CODE_SLOTS    (CODE_SLOTS)
    ) u_prob_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_prob (prob),
        .busy    (busy)
    );

    abre_coder #(
        .PENDING_BITS (PENDING_BITS)
    ) u_coder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .cur_range (cur_range),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_word.count, out_word.fill, out_word.lead};

endmodule

`default_nettype wire

### hw/rtl/abre_checker.sv
// Port-level checks for the adaptive binary range encoder, bound to the top level.
// No package dependency.
`default_nettype none

module abre_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // fill byte is 0xFF without carry or 0x00 with carry
    a_fill_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] == 8'hFF || m_axis_tdata[15:8] == 8'h00))
        else $error("fill byte neither 0x00 nor 0xFF");

    // nothing leaves while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // memory clearing keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !s_axis_tready)
        else $error("input ready before probability memories were cleared");

    // no word is taken during the clearing sweep start either
    a_no_accept_at_release: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !(s_axis_tvalid && s_axis_tready))
        else $error("word accepted on reset release");

endmodule

bind adaptive_binary_range_encoder abre_checker u_abre_checker (.*);

`default_nettype wire

### verif/tb.sv
// Self-checking bench for adaptive_binary_range_encoder: drives coded-bit and
// finish words, predicts every flush word and checks it on the output stream.
// Depends on abre_pkg and the encoder RTL only.
`timescale 1ns / 100ps

import abre_pkg::*;

localparam int LIT_SLOTS  = 256;
localparam int CODE_SLOTS = 32;

typedef struct {
    op_t        op;
    logic       bit_value;
    logic [2:0] model;
    logic [7:0] slot;
} code_word_t;

// Tracks coder state and the queue of flush words still owed by the block.
class flush_tracker;
    typedef struct {
        flush_word_t word;
        logic        last;
    } flush_due_t;

    flush_due_t        due_q[$];
    int unsigned       errors;
    logic [31:0]       rng;
    logic [63:0]       low;
    logic [7:0]        cache;
    logic [23:0]       pend;
    logic [PROB_W-1:0] type_p;
    logic [PROB_W-1:0] lit_p[LIT_SLOTS];
    logic [PROB_W-1:0] code_p[4*CODE_SLOTS];
    logic [SHIFT_W-1:0] shift_of[NUM_REGS];

    function new();
        rng    = RANGE_INIT;
        low    = '0;
        cache  = CACHE_INIT;
        pend   = '0;
        type_p = PROB_INIT;
        foreach (lit_p[i]) lit_p[i] = PROB_INIT;
        foreach (code_p[i]) code_p[i] = PROB_INIT;
        foreach (shift_of[i]) shift_of[i] = SHIFT_RESET_DEFAULT;
        shift_of[MODEL_LITERAL] = SHIFT_RESET_LITERAL;
        errors = 0;
    endfunction

    function void set_shift(logic [REG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] val);
        if (idx < NUM_REGS)
            shift_of[idx] = val;
    endfunction

    function int unsigned outstanding();
        return due_q.size();
    endfunction

    // one flush event: release cache plus pending fills once the top byte is settled
    function void shift_out();
        logic [31:0] lo32;
        logic        carry;
        flush_due_t  e;
        lo32  = low[31:0];
        carry = low[32];
        if (lo32 < 32'hFF00_0000 || carry) begin
            if (pend != 0) begin
                e.word.lead  = cache + {7'd0, carry};
                e.word.fill  = carry ? FILL_CARRY : FILL_NO_CARRY;
                e.word.count = pend - 24'd1;
                e.last       = 1'b0;
                due_q.push_back(e);
            end
            pend  = '0;
            cache = lo32[31:24];
        end
        if (pend != '1)
            pend = pend + 24'd1;
        low = {32'd0, lo32 << 8};
    endfunction

    function void absorb_word(code_word_t w);
        int unsigned start_n;
        int unsigned sh;
        int unsigned p;
        int unsigned idx;
        logic [31:0] thr;
        start_n = due_q.size();
        if (w.op == OP_FINISH) begin
            repeat (FLUSH_FINISH) shift_out();
        end
        else if (w.model <= MODEL_OFF_SUFFIX) begin
            sh = shift_of[w.model];
            if (sh == 0)
                sh = SHIFT_MIN;
            idx = 0;
            case (w.model)
                MODEL_TYPE:    p = type_p;
                MODEL_LITERAL: p = lit_p[w.slot % LIT_SLOTS];
                default:
                begin
                    idx = (w.model - MODEL_LEN_PREFIX) * CODE_SLOTS + w.slot % CODE_SLOTS;
                    p   = code_p[idx];
                end
            endcase
            thr = (rng >> 12) * p;
            if (!w.bit_value) begin
                rng = thr;
                p   = p + ((PROB_ONE - p) >> sh);
            end
            else begin
                rng = rng - thr;
                low = low + thr;
                p   = p - (p >> sh);
            end
            case (w.model)
                MODEL_TYPE:    type_p = p[PROB_W-1:0];
                MODEL_LITERAL: lit_p[w.slot % LIT_SLOTS] = p[PROB_W-1:0];
                default:       code_p[idx] = p[PROB_W-1:0];
            endcase
            while (rng < TOP_VALUE) begin
                rng = rng << 8;
                shift_out();
            end
        end
        if (due_q.size() > start_n)
            due_q[due_q.size()-1].last = 1'b1;
    endfunction

    function void match_flush(logic [39:0] data, logic lst);
        flush_word_t got;
        flush_due_t  e;
        got = data;
        if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected word: lead %02h fill %02h count %0d last %0b",
                         got.lead, got.fill, got.count, lst);
            return;
        end
        e = due_q.pop_front();
        if (got.lead != e.word.lead || got.fill != e.word.fill ||
            got.count != e.word.count || lst != e.last) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: want lead %02h fill %02h count %0d last %0b, got lead %02h fill %02h count %0d last %0b",
                         e.word.lead, e.word.fill, e.word.count, e.last,
                         got.lead, got.fill, got.count, lst);
        end
    endfunction
endclass

module tb;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_SHIFT       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LITERAL_SHIFT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEN_PREFIX_SHIFT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEN_SUFFIX_SHIFT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFF_PREFIX_SHIFT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFF_SUFFIX_SHIFT = 3'd5;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 4'd15;
    localparam logic [SHIFT_W-1:0] SHIFT_ZERO = 4'd0;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES   = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_addr;
    logic [SHIFT_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_axis_tready;
    logic [15:0]          s_data;
    logic                 s_user;
    logic                 m_axis_tvalid;
    logic                 m_tready;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tlast;

    flush_tracker book;
    logic         full_rate;
    int unsigned  hold_off;

    adaptive_binary_range_encoder #(
        .LITERAL_SLOTS(LIT_SLOTS),
        .CODE_SLOTS   (CODE_SLOTS),
        .PENDING_BITS (24)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_user),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int unsigned draw_gap();
        if (full_rate)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic code_word_t make_word(op_t op, logic b, logic [2:0] m, logic [7:0] s);
        code_word_t w;
        w.op        = op;
        w.bit_value = b;
        w.model     = m;
        w.slot      = s;
        return w;
    endfunction

    task automatic send_word(code_word_t w);
        int unsigned k;
        k = draw_gap();
        if (k > 0) begin
            s_valid <= 1'b0;
            repeat (k) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'd0, w.slot, w.model, w.bit_value};
        s_user  <= w.op;
        do @(posedge clk); while (!(s_valid && s_axis_tready));
        book.absorb_word(w);
    endtask

    task automatic write_shift(logic [REG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        book.set_shift(idx, val);
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // drain every owed flush word, then let a trailing no-output word retire
    task automatic settle();
        s_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one symbol: type decision, then a literal byte or a length/offset pair
    task automatic send_symbol(output int unsigned n);
        logic        is_match;
        logic [7:0]  lit;
        logic [3:0]  ctx;
        logic [2:0]  pre_m;
        logic [2:0]  suf_m;
        int unsigned len;
        n        = 0;
        is_match = ($urandom_range(0, 3) == 0);
        send_word(make_word(OP_BIT, is_match, MODEL_TYPE, 8'($urandom)));
        n++;
        if (!is_match) begin
            lit = $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom);
            ctx = 4'($urandom);
            for (int i = 7; i >= 0; i--) begin
                send_word(make_word(OP_BIT, lit[i], MODEL_LITERAL, {1'b0, 3'(7 - i), ctx}));
                n++;
            end
        end
        else begin
            for (int f = 0; f < 2; f++) begin
                pre_m = (f == 0) ? MODEL_LEN_PREFIX : MODEL_OFF_PREFIX;
                suf_m = (f == 0) ? MODEL_LEN_SUFFIX : MODEL_OFF_SUFFIX;
                len   = $urandom_range(0, 5);
                for (int i = 0; i < len; i++) begin
                    send_word(make_word(OP_BIT, 1'b1, pre_m, 8'(i)));
                    n++;
                end
                send_word(make_word(OP_BIT, 1'b0, pre_m, 8'(len)));
                n++;
                for (int i = 0; i < len; i++) begin
                    send_word(make_word(OP_BIT, 1'($urandom), suf_m, 8'(len * 5 + i)));
                    n++;
                end
            end
        end
    endtask

    task automatic random_traffic(int unsigned target);
        int unsigned sent;
        int unsigned pick;
        int unsigned n;
        code_word_t  w;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_word(make_word(OP_FINISH, 1'($urandom), 3'($urandom), 8'($urandom)));
                sent++;
            end
            else if (pick < 20) begin
                w = make_word(OP_BIT, 1'($urandom), 3'($urandom_range(0, 7)), 8'($urandom));
                send_word(w);
                if (w.model <= MODEL_OFF_SUFFIX)
                    sent++;
            end
            else begin
                send_symbol(n);
                sent += n;
            end
        end
    endtask

    // output side: random backpressure, one long hold-off on request
    initial begin : receiver
        int unsigned k;
        m_tready <= 1'b0;
        wait (rst_n);
        forever begin
            k = (hold_off > 0) ? hold_off : draw_gap();
            hold_off = 0;
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_tready));
            book.match_flush(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin : watchdog
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : main
        book      = new();
        full_rate = 1'b0;
        hold_off  = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_TYPE_SHIFT;
        cfg_wdata <= SHIFT_ZERO;
        s_valid   <= 1'b0;
        s_data    <= '0;
        s_user    <= OP_BIT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: finish on an empty cache, field extremes, every model,
        // ignored models, slot wrap, coding after finish
        send_word(make_word(OP_FINISH, 1'b0, MODEL_TYPE, 8'd0));
        send_word(make_word(OP_BIT, 1'b0, MODEL_TYPE, 8'd0));
        send_word(make_word(OP_BIT, 1'b1, MODEL_TYPE, 8'd255));
        send_word(make_word(OP_BIT, 1'b0, MODEL_LITERAL, 8'd255));
        send_word(make_word(OP_BIT, 1'b1, MODEL_LITERAL, 8'd0));
        send_word(make_word(OP_BIT, 1'b1, MODEL_LEN_PREFIX, 8'd31));
        send_word(make_word(OP_BIT, 1'b0, MODEL_LEN_SUFFIX, 8'd32));
        send_word(make_word(OP_BIT, 1'b1, MODEL_OFF_PREFIX, 8'd255));
        send_word(make_word(OP_BIT, 1'b0, MODEL_OFF_SUFFIX, 8'd200));
        send_word(make_word(OP_BIT, 1'b1, 3'd6, 8'd255));
        send_word(make_word(OP_BIT, 1'b0, 3'd7, 8'd0));
        // same slot hammered to push the probability toward its floor
        for (int i = 0; i < 6; i++)
            send_word(make_word(OP_BIT, 1'b1, MODEL_LITERAL, 8'd7));
        send_word(make_word(OP_FINISH, 1'b1, 3'd7, 8'd255));
        send_word(make_word(OP_BIT, 1'b0, MODEL_OFF_SUFFIX, 8'd31));
        send_word(make_word(OP_BIT, 1'b1, MODEL_LEN_PREFIX, 8'd0));
        send_word(make_word(OP_FINISH, 1'b0, MODEL_LITERAL, 8'd128));
        random_traffic(100);
        settle();

        // slowest adaptation, with a long output stall
        for (int r = REG_TYPE_SHIFT; r <= REG_OFF_SUFFIX_SHIFT; r++)
            write_shift(REG_IDX_W'(r), SHIFT_MAX);
        end_writes();
        hold_off = HOLD_CYCLES;
        random_traffic(110);
        settle();

        // fastest adaptation; a zero shift behaves as one
        write_shift(REG_TYPE_SHIFT, SHIFT_ZERO);
        write_shift(REG_LITERAL_SHIFT, SHIFT_MIN);
        write_shift(REG_LEN_PREFIX_SHIFT, SHIFT_MIN);
        write_shift(REG_LEN_SUFFIX_SHIFT, SHIFT_ZERO);
        write_shift(REG_OFF_PREFIX_SHIFT, SHIFT_MIN);
        write_shift(REG_OFF_SUFFIX_SHIFT, SHIFT_ZERO);
        end_writes();
        random_traffic(110);
        settle();

        // mixed shifts, both sides at full rate
        for (int r = REG_TYPE_SHIFT; r <= REG_OFF_SUFFIX_SHIFT; r++)
            write_shift(REG_IDX_W'(r), SHIFT_W'($urandom_range(0, 15)));
        end_writes();
        full_rate = 1'b1;
        random_traffic(110);
        settle();
        repeat (40) @(posedge clk);

        if (book.errors == 0 && book.outstanding() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/abre_pkg.sv
hw/rtl/abre_prob_store.sv
hw/rtl/abre_coder.sv
hw/rtl/adaptive_binary_range_encoder.sv
hw/rtl/abre_checker.sv
verif/tb.sv
